// ===== design/tfds_pkg.sv =====
// Shared types, constants and the microcode program for the timer divide factor search.
package tfds_pkg;

   localparam int TARGET_W  = 34;
   localparam int CODE_W    = 2;
   localparam int COUNT_W   = 16;
   localparam int REDUCED_W = 32;
   localparam int PSC_W     = COUNT_W + 1;   // candidates run up to 2^16 inclusive
   localparam int DVD_W     = REDUCED_W + 1; // reduced plus half the prescaler
   localparam int PROD_W    = 2 * PSC_W;
   localparam int PC_W      = 3;
   localparam int DIV_CNT_W = 6;

   localparam logic [PSC_W-1:0]    PSC_LAST = PSC_W'(32'h1_0000);
   localparam logic [TARGET_W-1:0] MAX_DIV  = {TARGET_W{1'b1}};
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = DIV_CNT_W'(DVD_W);

   localparam logic [CODE_W-1:0] CODE_DIV1 = 2'd0;
   localparam logic [CODE_W-1:0] CODE_DIV2 = 2'd1;
   localparam logic [CODE_W-1:0] CODE_DIV4 = 2'd2;

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_WAIT     = 3'd0;
   localparam pc_type PC_SETUP    = 3'd1;
   localparam pc_type PC_DIV_LOAD = 3'd2;
   localparam pc_type PC_DIV_STEP = 3'd3;
   localparam pc_type PC_EVAL     = 3'd4;
   localparam pc_type PC_MUL      = 3'd5;
   localparam pc_type PC_OUT      = 3'd6;
   localparam pc_type PC_ERR      = 3'd7;

   typedef enum logic [2:0] {
      OP_WAIT,
      OP_SETUP,
      OP_DIV_LOAD,
      OP_DIV_STEP,
      OP_EVAL,
      OP_MUL,
      OP_OUT,
      OP_ERR
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,       // fall through
      COND_ALWAYS,
      COND_NO_START,
      COND_ZERO,
      COND_DIV_MORE,
      COND_SEARCH_MORE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   target;
   } uword_type;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   function automatic uword_type microcode(input pc_type pc);
      uword_type w;
      begin
         case (pc)
            PC_WAIT:     w = '{OP_WAIT,     COND_NO_START,    PC_WAIT};
            PC_SETUP:    w = '{OP_SETUP,    COND_ZERO,        PC_ERR};
            PC_DIV_LOAD: w = '{OP_DIV_LOAD, COND_NONE,        PC_WAIT};
            PC_DIV_STEP: w = '{OP_DIV_STEP, COND_DIV_MORE,    PC_DIV_STEP};
            PC_EVAL:     w = '{OP_EVAL,     COND_SEARCH_MORE, PC_DIV_LOAD};
            PC_MUL:      w = '{OP_MUL,      COND_NONE,        PC_WAIT};
            PC_OUT:      w = '{OP_OUT,      COND_ALWAYS,      PC_WAIT};
            PC_ERR:      w = '{OP_ERR,      COND_ALWAYS,      PC_WAIT};
            default:     w = '{OP_WAIT,     COND_ALWAYS,      PC_WAIT};
         endcase
         return w;
      end
   endfunction

endpackage

// ===== design/tfds_div.sv =====
// Bit-serial restoring divider: one quotient bit per step.
module tfds_div
   import tfds_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  div_ctl_type        ctl,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [PSC_W-1:0]   divisor,
   output logic [DVD_W-1:0]   quotient,
   output logic [PSC_W-1:0]   remainder,
   output logic               last
);

   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [PSC_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PSC_W:0]       rem_sh;
   logic                 ge;

   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge     = rem_sh >= {1'b0, divisor};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (ctl.load) begin
         dvd_in = dividend;
         rem_in = '0;
         cnt_in = DIV_STEPS;
      end else if (ctl.step) begin
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         rem_in = ge ? PSC_W'(rem_sh - {1'b0, divisor}) : rem_sh[PSC_W-1:0];
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
   end

   assign quotient  = dvd_ff;
   assign remainder = rem_ff;
   assign last      = (cnt_ff == DIV_CNT_W'(1));

endmodule

// ===== design/timer_divider_factor_search.sv =====
// Top level of the timer divide factor search: microcode sequencer and datapath.
//
// Splits a requested total divide into a clock-division step (1, 2 or 4), a
// prescaler and an autoload. A request is taken when start is high and busy is
// low; busy then stays high until the cycle in which the single result is shown.
// The result appears on the rsp_ ports for exactly one cycle with rsp_valid high
// and cannot be held off, so capture it on that cycle. Each prescaler candidate
// takes a divider load, the bit-serial divide steps and one compare, and up to
// 65536 candidates are tried, one after another; the search ends early on an
// exact hit. A zero target returns div_error with every other field zero.
// achieved_div saturates at 2^34 - 1.
module timer_divider_factor_search
   import tfds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [TARGET_W-1:0]  req_target_div,
   output logic                 rsp_valid,
   output logic [CODE_W-1:0]    rsp_clk_div_code,
   output logic [COUNT_W-1:0]   rsp_prescaler_value,
   output logic [COUNT_W-1:0]   rsp_autoload_value,
   output logic [TARGET_W-1:0]  rsp_achieved_div,
   output logic                 rsp_div_error
);

   // sequencer
   pc_type      pc_ff, pc_in;
   uword_type   uw;
   logic        take_jump;

   // datapath registers
   logic [TARGET_W-1:0]  target_ff, target_in;
   logic [CODE_W-1:0]    code_ff, code_in;
   logic [REDUCED_W-1:0] reduced_ff, reduced_in;
   logic [PSC_W-1:0]     psc_ff, psc_in;
   logic [PSC_W-1:0]     best_psc_ff, best_psc_in;
   logic [PSC_W-1:0]     best_al_ff, best_al_in;
   logic [PSC_W-1:0]     best_err_ff, best_err_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   // result registers
   logic                 valid_ff, valid_in;
   logic [CODE_W-1:0]    out_code_ff, out_code_in;
   logic [COUNT_W-1:0]   out_psc_ff, out_psc_in;
   logic [COUNT_W-1:0]   out_al_ff, out_al_in;
   logic [TARGET_W-1:0]  out_ach_ff, out_ach_in;
   logic                 out_err_ff, out_err_in;

   // divider
   div_ctl_type          div_ctl;
   logic [DVD_W-1:0]     div_quo;
   logic [PSC_W-1:0]     div_rem;
   logic                 div_last;

   // decoded setup values
   logic [CODE_W-1:0]    setup_code;
   logic [REDUCED_W-1:0] setup_reduced;

   // candidate evaluation
   logic [PSC_W-2:0]     half_psc;
   logic [PSC_W-1:0]     cand_err;
   logic                 better;
   logic                 stop;
   logic [TARGET_W+CODE_W-1:0] scaled;

   assign uw = microcode(pc_ff);

   // Step is target / 2^32 + 1; a step of 3 rounds up to 4. A 34-bit target
   // never asks for more than 4.
   always_comb begin
      case (target_ff[TARGET_W-1:TARGET_W-2])
         2'd0:    setup_code = CODE_DIV1;
         2'd1:    setup_code = CODE_DIV2;
         default: setup_code = CODE_DIV4;
      endcase
   end
   assign setup_reduced = REDUCED_W'(target_ff >> setup_code);

   // n = al * p + r with n = reduced + p/2, so al * p - reduced = p/2 - r.
   assign half_psc = psc_ff[PSC_W-1:1];
   assign cand_err = ({1'b0, half_psc} >= div_rem) ? ({1'b0, half_psc} - div_rem)
                                                   : (div_rem - {1'b0, half_psc});
   assign better   = cand_err < best_err_ff;
   assign stop     = (better && (cand_err == '0)) || (psc_ff == PSC_LAST);

   assign scaled = {2'b00, prod_ff} << code_ff;

   always_comb begin
      case (uw.cond)
         COND_NONE:        take_jump = 1'b0;
         COND_ALWAYS:      take_jump = 1'b1;
         COND_NO_START:    take_jump = !start;
         COND_ZERO:        take_jump = (target_ff == '0);
         COND_DIV_MORE:    take_jump = !div_last;
         COND_SEARCH_MORE: take_jump = !stop;
         default:          take_jump = 1'b0;
      endcase
      pc_in = take_jump ? uw.target : pc_type'(pc_ff + 1'b1);
   end

   always_comb begin
      target_in   = target_ff;
      code_in     = code_ff;
      reduced_in  = reduced_ff;
      psc_in      = psc_ff;
      best_psc_in = best_psc_ff;
      best_al_in  = best_al_ff;
      best_err_in = best_err_ff;
      prod_in     = prod_ff;
      valid_in    = 1'b0;
      out_code_in = out_code_ff;
      out_psc_in  = out_psc_ff;
      out_al_in   = out_al_ff;
      out_ach_in  = out_ach_ff;
      out_err_in  = out_err_ff;
      div_ctl     = '0;

      case (uw.op)
         OP_WAIT: begin
            target_in = req_target_div;
         end
         OP_SETUP: begin
            code_in     = setup_code;
            reduced_in  = setup_reduced;
            psc_in      = {1'b0, setup_reduced[REDUCED_W-1:REDUCED_W-COUNT_W]} + 1'b1;
            best_err_in = '1;   // first candidate always wins
         end
         OP_DIV_LOAD: begin
            div_ctl.load = 1'b1;
         end
         OP_DIV_STEP: begin
            div_ctl.step = 1'b1;
         end
         OP_EVAL: begin
            if (better) begin
               best_psc_in = psc_ff;
               best_al_in  = div_quo[PSC_W-1:0];
               best_err_in = cand_err;
            end
            if (!stop) begin
               psc_in = psc_ff + 1'b1;
            end
         end
         OP_MUL: begin
            prod_in = best_psc_ff * best_al_ff;
         end
         OP_OUT: begin
            valid_in    = 1'b1;
            out_code_in = code_ff;
            out_psc_in  = COUNT_W'(best_psc_ff - 1'b1);
            out_al_in   = COUNT_W'(best_al_ff - 1'b1);
            out_ach_in  = (scaled > {{CODE_W{1'b0}}, MAX_DIV}) ? MAX_DIV
                                                              : scaled[TARGET_W-1:0];
            out_err_in  = 1'b0;
         end
         OP_ERR: begin
            valid_in    = 1'b1;
            out_code_in = '0;
            out_psc_in  = '0;
            out_al_in   = '0;
            out_ach_in  = '0;
            out_err_in  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   tfds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (DVD_W'(reduced_ff) + DVD_W'(half_psc)),
      .divisor   (psc_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .last      (div_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= PC_WAIT;
         valid_ff <= 1'b0;
      end else begin
         pc_ff    <= pc_in;
         valid_ff <= valid_in;
      end
      target_ff   <= target_in;
      code_ff     <= code_in;
      reduced_ff  <= reduced_in;
      psc_ff      <= psc_in;
      best_psc_ff <= best_psc_in;
      best_al_ff  <= best_al_in;
      best_err_ff <= best_err_in;
      prod_ff     <= prod_in;
      out_code_ff <= out_code_in;
      out_psc_ff  <= out_psc_in;
      out_al_ff   <= out_al_in;
      out_ach_ff  <= out_ach_in;
      out_err_ff  <= out_err_in;
   end

   assign busy                = (pc_ff != PC_WAIT);
   assign rsp_valid           = valid_ff;
   assign rsp_clk_div_code    = out_code_ff;
   assign rsp_prescaler_value = out_psc_ff;
   assign rsp_autoload_value  = out_al_ff;
   assign rsp_achieved_div    = out_ach_ff;
   assign rsp_div_error       = out_err_ff;

endmodule

// ===== sim/testbench.sv =====
// Testbench for timer_divider_factor_search: request driver, split predictor and result checker.
module testbench
   import tfds_pkg::*;
();

   // 2^COUNT_W * 2^16: the step is target / WORD_SPAN + 1
   localparam logic [63:0] WORD_SPAN    = 64'h1_0000_0000;
   localparam int          MAX_STEP     = 4;
   // random requests are kept to searches of at most this many candidates
   localparam int          TRY_CAP      = 400;
   localparam int          RANDOM_COUNT = 100;
   localparam int          DRAIN_CYCLES = 100;
   // ~117 requests of up to 400 candidates each plus slack, taken more than 3x over
   localparam int unsigned RUN_LIMIT    = 6_000_000;

   typedef struct {
      logic [CODE_W-1:0]   clk_div_code;
      logic [COUNT_W-1:0]  prescaler_value;
      logic [COUNT_W-1:0]  autoload_value;
      logic [TARGET_W-1:0] achieved_div;
      logic                div_error;
      int unsigned         tries;          // candidates the search visits
   } split_result_type;

   // Holds the splits still owed by the block and checks each response.
   class split_checker;
      split_result_type pending_splits[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Bit-exact expectation for one target divide.
      static function split_result_type split_divide(input logic [TARGET_W-1:0] target);
         split_result_type split;
         logic [63:0]      wide, step, reduced, psc, best_psc, autoload;
         logic [63:0]      product, miss, best_miss, achieved;
         bit               have_best;
         split.clk_div_code    = '0;
         split.prescaler_value = '0;
         split.autoload_value  = '0;
         split.achieved_div    = '0;
         split.div_error       = 1'b1;
         split.tries           = 0;
         wide = 64'(target);
         step = wide / WORD_SPAN + 1;
         // too high or zero: error flag only
         if (step > MAX_STEP || wide == 0)
            return split;
         if (step == 3)
            step = MAX_STEP;
         reduced   = wide / step;
         psc       = (reduced >> COUNT_W) + 1;
         best_psc  = psc;
         best_miss = '0;
         have_best = 1'b0;
         forever begin
            split.tries = split.tries + 1;
            autoload = (reduced + psc / 2) / psc;
            product  = autoload * psc;
            miss     = (product > reduced) ? product - reduced : reduced - product;
            // strictly smaller only: the first candidate wins a tie
            if (!have_best || miss < best_miss) begin
               have_best = 1'b1;
               best_miss = miss;
               best_psc  = psc;
               if (miss == 0)
                  break;
            end
            if (psc >= 64'(PSC_LAST))
               break;
            psc = psc + 1;
         end
         autoload = (reduced + best_psc / 2) / best_psc;
         achieved = step * best_psc * autoload;
         if (achieved > 64'(MAX_DIV))
            achieved = 64'(MAX_DIV);
         split.clk_div_code    = (step == 1) ? CODE_DIV1 : (step == 2) ? CODE_DIV2 : CODE_DIV4;
         split.prescaler_value = COUNT_W'(best_psc - 1);
         split.autoload_value  = COUNT_W'(autoload - 1);
         split.achieved_div    = TARGET_W'(achieved);
         split.div_error       = 1'b0;
         return split;
      endfunction

      function void note_request(input logic [TARGET_W-1:0] target);
         pending_splits.push_back(split_divide(target));
      endfunction

      function void check_result(input logic [CODE_W-1:0]   clk_div_code,
                                 input logic [COUNT_W-1:0]  prescaler_value,
                                 input logic [COUNT_W-1:0]  autoload_value,
                                 input logic [TARGET_W-1:0] achieved_div,
                                 input logic                div_error);
         split_result_type want;
         if (pending_splits.size() == 0) begin
            if (mismatches < 10)
               $display("response with no request outstanding: code %0d psc %0d al %0d div %0d err %0b",
                        clk_div_code, prescaler_value, autoload_value, achieved_div, div_error);
            mismatches++;
            return;
         end
         want = pending_splits.pop_front();
         if (clk_div_code !== want.clk_div_code || prescaler_value !== want.prescaler_value ||
             autoload_value !== want.autoload_value || achieved_div !== want.achieved_div ||
             div_error !== want.div_error) begin
            if (mismatches < 10) begin
               $display("mismatch: expected code %0d psc %0d al %0d div %0d err %0b",
                        want.clk_div_code, want.prescaler_value, want.autoload_value,
                        want.achieved_div, want.div_error);
               $display("          actual   code %0d psc %0d al %0d div %0d err %0b",
                        clk_div_code, prescaler_value, autoload_value, achieved_div, div_error);
            end
            mismatches++;
         end
      endfunction
   endclass

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic [TARGET_W-1:0] req_target_div = '0;
   logic                busy;
   logic                rsp_valid;
   logic [CODE_W-1:0]   rsp_clk_div_code;
   logic [COUNT_W-1:0]  rsp_prescaler_value;
   logic [COUNT_W-1:0]  rsp_autoload_value;
   logic [TARGET_W-1:0] rsp_achieved_div;
   logic                rsp_div_error;

   split_checker        split_check;
   bit                  steady_sender  = 1'b0;   // no idle cycles while set
   int unsigned         cycle_count    = 0;

   timer_divider_factor_search i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_target_div      (req_target_div),
      .rsp_valid           (rsp_valid),
      .rsp_clk_div_code    (rsp_clk_div_code),
      .rsp_prescaler_value (rsp_prescaler_value),
      .rsp_autoload_value  (rsp_autoload_value),
      .rsp_achieved_div    (rsp_achieved_div),
      .rsp_div_error       (rsp_div_error)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Hard stop in case the block hangs or a search runs away.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // Responses last one cycle and cannot be stalled: take every one.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && split_check != null)
         split_check.check_result(rsp_clk_div_code, rsp_prescaler_value, rsp_autoload_value,
                                  rsp_achieved_div, rsp_div_error);
   end

   // Target that is step * psc * autoload exactly, plus a remainder below the step.
   // Steps 2 and 4 need psc * autoload >= 2^31, otherwise step 1 is used.
   function automatic logic [TARGET_W-1:0] product_target(input int unsigned psc,
                                                          input int unsigned autoload,
                                                          input int unsigned step,
                                                          input int unsigned rest);
      logic [63:0] reduced;
      reduced = 64'(psc) * 64'(autoload);
      if (reduced < 64'h8000_0000)
         step = 1;
      return TARGET_W'(reduced * step + rest % step);
   endfunction

   // One random target. Most are exact products so the search stops early;
   // the rest are zeros, near misses and raw values; any long search is redrawn.
   function automatic logic [TARGET_W-1:0] draw_target();
      logic [TARGET_W-1:0] target;
      int unsigned         kind, width;
      split_result_type    probe;
      do begin
         kind = $urandom_range(99);
         if (kind < 3)
            target = '0;
         else if (kind < 60)
            // autoload near full scale: the divisor psc is within ~64 of the start
            target = product_target($urandom_range(65535, 1), $urandom_range(65535, 65472),
                                    1 << $urandom_range(2), $urandom);
         else if (kind < 72)
            target = product_target($urandom_range(300, 1), $urandom_range(65535, 1), 1, 0);
         else if (kind < 86)
            // near miss: rounding and error comparison get exercised
            target = product_target($urandom_range(65535, 1), $urandom_range(65535, 65472),
                                    1 << $urandom_range(2), $urandom)
                     + TARGET_W'($urandom_range(600)) - TARGET_W'(300);
         else begin
            width  = $urandom_range(TARGET_W, 1);
            target = TARGET_W'({$urandom, $urandom}) & TARGET_W'((64'd1 << width) - 1);
         end
         probe = split_checker::split_divide(target);
      end while (probe.tries > TRY_CAP);
      return target;
   endfunction

   // Present one request and hold it until the block takes it.
   task automatic issue_request(input logic [TARGET_W-1:0] target);
      // idle cycles put junk on the bus; it must be ignored
      while (!steady_sender && $urandom_range(99) < 33) begin
         start          <= 1'b0;
         req_target_div <= TARGET_W'({$urandom, $urandom});
         @(posedge clock);
      end
      start          <= 1'b1;
      req_target_div <= target;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      split_check.note_request(target);
   endtask

   initial begin
      logic [TARGET_W-1:0] directed_targets[$];
      split_check = new();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero target: error, everything else zero
      directed_targets.push_back('0);
      // smallest targets: below 2^16 psc 1 hits at once, 65536 hits at psc 2
      directed_targets.push_back(TARGET_W'(1));
      directed_targets.push_back(TARGET_W'(2));
      directed_targets.push_back(TARGET_W'(7));
      directed_targets.push_back(TARGET_W'(65535));
      directed_targets.push_back(TARGET_W'(65536));
      // all ones: step of 4, autoload rounds to 2^16, divide saturates
      directed_targets.push_back(MAX_DIV);
      // top of step 1 and step 2: a single candidate, at the end of the range
      directed_targets.push_back(TARGET_W'(64'hFFFF_FFFF));
      directed_targets.push_back(TARGET_W'(64'h1_FFFF_FFFF));
      // prime just below 2^32: no exact hit, the single candidate is the last one
      directed_targets.push_back(TARGET_W'(64'd4294967291));
      // full-scale prescaler and autoload at each step, with remainders at steps 2 and 4
      directed_targets.push_back(product_target(65535, 65535, 1, 0));
      directed_targets.push_back(product_target(65535, 65535, 2, 1));
      directed_targets.push_back(product_target(65535, 65535, 4, 3));
      // step of 3 raised to 4, a plain step of 4, and two small step-1 products
      directed_targets.push_back(product_target(40000, 65535, 4, 2));
      directed_targets.push_back(product_target(60000, 65500, 4, 1));
      directed_targets.push_back(product_target(3, 21845, 1, 0));
      directed_targets.push_back(product_target(300, 40000, 1, 0));

      foreach (directed_targets[i])
         issue_request(directed_targets[i]);

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         steady_sender = (i >= 40 && i < 70);   // back-to-back stretch
         issue_request(draw_target());
      end

      start <= 1'b0;
      while (split_check.pending_splits.size() != 0)
         @(posedge clock);
      // catch any stray response after the last one
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (split_check.mismatches == 0 && split_check.pending_splits.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
